FILE: rtl/core/otp_pkg.sv
// Shared types, codes and alphabet functions of the one-time-pad symbol cipher.
`default_nettype none

package otp_pkg;

    localparam int unsigned REG_W      = 14;  // configuration registers and module pointers
    localparam int unsigned TEXT_W     = 8;
    localparam int unsigned PAD_ADDR_W = 18;
    localparam int unsigned PAD_DATA_W = 8;
    localparam int unsigned SYM_W      = 7;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 24;

    typedef enum logic [1:0] {
        MODE_LOAD_SEND = 2'd0,
        MODE_LOAD_RECV = 2'd1,
        MODE_SEND      = 2'd2,
        MODE_RECV      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_SYMBOL    = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_LOADED    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_SEND_START = 2'd0,
        CFG_SEND_END   = 2'd1,
        CFG_RECV_START = 2'd2,
        CFG_RECV_END   = 2'd3
    } cfg_index_t;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;
    localparam logic [7:0] CHAR_DOT        = 8'd46;
    localparam logic [7:0] CHAR_UPPER_A    = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A    = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'd122;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'd57;

    // Byte to alphabet index; bytes outside the alphabet give index 0.
    function automatic logic [IDX_W-1:0] sym_index(input logic [TEXT_W-1:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = c - 8'd64;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = c - 8'd70;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            v = c + 8'd5;
        end else if (c == CHAR_DOT) begin
            v = 8'd63;
        end
        return v[IDX_W-1:0];
    endfunction

    // Alphabet index to its ASCII character.
    function automatic logic [SYM_W-1:0] sym_char(input logic [IDX_W-1:0] i);
        logic [7:0] v;
        logic [7:0] w;
        w = {2'b00, i};
        if (w == 8'd0) begin
            v = CHAR_UNDERSCORE;
        end else if (w <= 8'd26) begin
            v = w + 8'd64;
        end else if (w <= 8'd52) begin
            v = w + 8'd70;
        end else if (w <= 8'd62) begin
            v = w - 8'd5;
        end else begin
            v = CHAR_DOT;
        end
        return v[SYM_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/otp_base64_symbol_cipher.sv
// One-time-pad symbol cipher: pad memory banks, pointer state and a two-stage pipeline.
//
// Use: a word on the s_axis channel either loads one pad byte (tuser selects the
// outgoing or incoming region) or enciphers one text character with the next six
// pad bits of the current module of its direction. Every accepted word gives exactly
// one result word on m_axis: the alphabet symbol in tdata, the status in tuser and
// tlast set on the last symbol of a module. The cfg channel writes the start and end
// module registers; a start write also rewinds that direction's pointer.
// An input word passes the read stage and then the output register on its way out.
// Throughput: one word per cycle while the receiver does not stall.
// The pad sits in two byte-wide banks (even and odd addresses), each with one read
// and one write port, so a symbol reads both of its bytes and erases a spent byte in
// the cycle it is accepted.
// Reset loads the register reset values and clears the pointers and the symbol
// positions; the pad memory keeps its contents and needs no clearing pass.
// When the receiver stalls, the output register and the read stage hold their words
// and s_axis_tready drops once both are full; nothing is lost or repeated.
`default_nettype none

module otp_base64_symbol_cipher #(
    parameter int unsigned MODULE_BYTES = 18,
    parameter int unsigned MODULE_COUNT = 8192
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // text_byte [7:0], pad_address [25:8], pad_data [33:26], zero fill above
    input  wire logic [otp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // mode [1:0]
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // symbol_out [6:0], modules_left [20:7], zero fill above
    output logic [otp_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    // status [1:0]
    output logic [1:0]                             m_axis_tuser,
    // module_done
    output logic                                   m_axis_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [otp_pkg::REG_W-1:0]         cfg_data
);

    localparam int unsigned REGION_BYTES = MODULE_BYTES * MODULE_COUNT;
    localparam int unsigned SYMS_PER_MOD = (MODULE_BYTES / 3) * 4;
    localparam int unsigned AW           = $clog2(2 * REGION_BYTES);
    localparam int unsigned BANK_DEPTH   = REGION_BYTES;
    localparam int unsigned BANK_AW      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int unsigned POS_W        = $clog2(SYMS_PER_MOD);
    localparam int unsigned BIT_W        = POS_W + 3;
    localparam int unsigned RW           = otp_pkg::REG_W;

    // ------------------------------------------------------------------
    // Input word unpacking
    // ------------------------------------------------------------------
    otp_pkg::mode_t                       in_mode;
    logic [otp_pkg::TEXT_W-1:0]           in_text;
    logic [otp_pkg::PAD_ADDR_W-1:0]       in_addr;
    logic [otp_pkg::PAD_DATA_W-1:0]       in_data;

    assign in_mode = otp_pkg::mode_t'(s_axis_tuser);
    assign in_text = s_axis_tdata[7:0];
    assign in_addr = s_axis_tdata[25:8];
    assign in_data = s_axis_tdata[33:26];

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [RW-1:0]    send_end_reg;
    logic [RW-1:0]    recv_end_reg;
    logic [RW-1:0]    send_ptr_reg, send_ptr_next;
    logic [RW-1:0]    recv_ptr_reg, recv_ptr_next;
    logic [POS_W-1:0] send_pos_reg, send_pos_next;
    logic [POS_W-1:0] recv_pos_reg, recv_pos_next;

    // Read stage
    logic                   s1_valid_reg, s1_valid_next;
    otp_pkg::status_t       s1_status_reg;
    logic [2:0]             s1_sh_reg;
    logic [otp_pkg::IDX_W-1:0] s1_tidx_reg;
    logic                   s1_swap_reg;
    logic                   s1_done_reg;
    logic [RW-1:0]          s1_left_reg;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [otp_pkg::SYM_W-1:0] out_sym_reg;
    otp_pkg::status_t       out_status_reg;
    logic                   out_done_reg;
    logic [RW-1:0]          out_left_reg;

    logic in_fire;
    logic s1_advance;

    assign cfg_ready     = 1'b1;
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Accept stage: address, status and pointer update
    // ------------------------------------------------------------------
    logic              incoming;
    logic              is_load;
    logic [RW-1:0]     ptr_cur;
    logic [RW-1:0]     end_cur;
    logic [POS_W-1:0]  pos_cur;
    logic              exhausted;
    logic              do_symbol;
    logic [BIT_W-1:0]  bit_pos;
    logic [POS_W-1:0]  byte_idx;
    logic [2:0]        bit_sh;
    logic [AW-1:0]     region_base;
    logic [AW-1:0]     mod_base;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     load_addr;
    logic              load_in_range;
    logic              pos_last;
    logic [RW-1:0]     ptr_after;
    logic [POS_W-1:0]  pos_after;
    logic [RW-1:0]     left_after;
    otp_pkg::status_t  acc_status;

    assign incoming  = in_mode[0];
    assign is_load   = (in_mode == otp_pkg::MODE_LOAD_SEND) ||
                       (in_mode == otp_pkg::MODE_LOAD_RECV);
    assign ptr_cur   = incoming ? recv_ptr_reg : send_ptr_reg;
    assign end_cur   = incoming ? recv_end_reg : send_end_reg;
    assign pos_cur   = incoming ? recv_pos_reg : send_pos_reg;
    assign exhausted = (ptr_cur >= end_cur) || (32'(ptr_cur) >= MODULE_COUNT);
    assign do_symbol = !is_load && !exhausted;

    assign bit_pos     = BIT_W'(pos_cur) * BIT_W'(6);
    assign byte_idx    = bit_pos[BIT_W-1:3];
    assign bit_sh      = bit_pos[2:0];
    assign region_base = incoming ? AW'(REGION_BYTES) : '0;
    assign mod_base    = region_base + AW'(ptr_cur) * AW'(MODULE_BYTES);
    assign rd_addr     = mod_base + AW'(byte_idx);
    assign load_in_range = 32'(in_addr) < REGION_BYTES;
    assign load_addr   = region_base + AW'(in_addr);

    assign pos_last  = 32'(pos_cur) == (SYMS_PER_MOD - 1);
    assign ptr_after = (do_symbol && pos_last) ? ptr_cur + RW'(1) : ptr_cur;
    assign pos_after = pos_last ? '0 : pos_cur + POS_W'(1);
    assign left_after = (end_cur > ptr_after) ? end_cur - ptr_after : '0;

    always_comb begin
        if (is_load) begin
            acc_status = otp_pkg::STATUS_LOADED;
        end else if (exhausted) begin
            acc_status = otp_pkg::STATUS_EXHAUSTED;
        end else begin
            acc_status = otp_pkg::STATUS_SYMBOL;
        end
    end

    always_comb begin
        send_ptr_next = send_ptr_reg;
        recv_ptr_next = recv_ptr_reg;
        send_pos_next = send_pos_reg;
        recv_pos_next = recv_pos_reg;
        if (in_fire && do_symbol) begin
            if (incoming) begin
                recv_ptr_next = ptr_after;
                recv_pos_next = pos_after;
            end else begin
                send_ptr_next = ptr_after;
                send_pos_next = pos_after;
            end
        end
        // A start write rewinds its direction; user sends it only when idle, unchecked.
        if (cfg_valid && cfg_ready) begin
            if (otp_pkg::cfg_index_t'(cfg_index) == otp_pkg::CFG_SEND_START) begin
                send_ptr_next = cfg_data;
                send_pos_next = '0;
            end
            if (otp_pkg::cfg_index_t'(cfg_index) == otp_pkg::CFG_RECV_START) begin
                recv_ptr_next = cfg_data;
                recv_pos_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_end_reg <= RW'(8192);
            recv_end_reg <= RW'(8192);
            send_ptr_reg <= '0;
            recv_ptr_reg <= '0;
            send_pos_reg <= '0;
            recv_pos_reg <= '0;
        end else begin
            send_ptr_reg <= send_ptr_next;
            recv_ptr_reg <= recv_ptr_next;
            send_pos_reg <= send_pos_next;
            recv_pos_reg <= recv_pos_next;
            if (cfg_valid && cfg_ready) begin
                unique case (otp_pkg::cfg_index_t'(cfg_index))
                    otp_pkg::CFG_SEND_END: begin
                        send_end_reg <= cfg_data;
                    end
                    otp_pkg::CFG_RECV_END: begin
                        recv_end_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Pad memory: even and odd byte banks
    // ------------------------------------------------------------------
    // A symbol reads the byte at rd_addr and the one after it, which always lie in
    // different banks. The byte whose last bit a symbol uses is erased in the same
    // cycle; reads return the old contents. Trailing bytes of a module are never
    // read by a symbol, so they are left as loaded.
    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];
    logic [7:0] even_rd_reg;
    logic [7:0] odd_rd_reg;

    logic [BANK_AW-1:0] rd_half;
    logic [BANK_AW-1:0] rd_half_inc;
    logic [BANK_AW-1:0] even_ridx;
    logic [BANK_AW-1:0] odd_ridx;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic [BANK_AW-1:0] wr_idx;

    assign rd_half     = BANK_AW'(rd_addr >> 1);
    assign rd_half_inc = (32'(rd_half) == BANK_DEPTH - 1) ? '0 : rd_half + BANK_AW'(1);
    assign even_ridx   = rd_addr[0] ? rd_half_inc : rd_half;
    assign odd_ridx    = rd_half;

    assign wr_en   = in_fire && ((is_load && load_in_range) || (do_symbol && bit_sh >= 3'd2));
    assign wr_addr = is_load ? load_addr : rd_addr;
    assign wr_data = is_load ? in_data : 8'd0;
    assign wr_idx  = BANK_AW'(wr_addr >> 1);

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_addr[0]) begin
            even_mem[wr_idx] <= wr_data;
        end
        if (in_fire) begin
            even_rd_reg <= even_mem[even_ridx];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr[0]) begin
            odd_mem[wr_idx] <= wr_data;
        end
        if (in_fire) begin
            odd_rd_reg <= odd_mem[odd_ridx];
        end
    end

    // ------------------------------------------------------------------
    // Read stage
    // ------------------------------------------------------------------
    always_comb begin
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_status_reg <= acc_status;
            s1_sh_reg     <= bit_sh;
            s1_tidx_reg   <= otp_pkg::sym_index(in_text);
            s1_swap_reg   <= rd_addr[0];
            s1_done_reg   <= do_symbol && pos_last;
            s1_left_reg   <= left_after;
        end
    end

    logic [7:0]                b0;
    logic [7:0]                b1;
    logic [15:0]               key_window;
    logic [otp_pkg::IDX_W-1:0] key;
    logic [otp_pkg::SYM_W-1:0] s1_sym;

    assign b0         = s1_swap_reg ? odd_rd_reg : even_rd_reg;
    assign b1         = s1_swap_reg ? even_rd_reg : odd_rd_reg;
    // Six bits starting sh bits into b0, most significant bit first.
    assign key_window = {b0, b1} >> (4'd10 - {1'b0, s1_sh_reg});
    assign key        = key_window[otp_pkg::IDX_W-1:0];
    assign s1_sym     = (s1_status_reg == otp_pkg::STATUS_SYMBOL) ?
                        otp_pkg::sym_char(s1_tidx_reg ^ key) : '0;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        if (s1_advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            out_sym_reg    <= s1_sym;
            out_status_reg <= s1_status_reg;
            out_done_reg   <= s1_done_reg;
            out_left_reg   <= s1_left_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_left_reg, out_sym_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every alphabet character is nonzero, so a produced symbol can never read as 0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == otp_pkg::STATUS_SYMBOL) |-> m_axis_tdata[6:0] != '0)
        else $error("symbol word carries a zero symbol");

    // The end of a module is only flagged on a produced symbol.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == otp_pkg::STATUS_SYMBOL)
        else $error("module end flagged on a word without a symbol");

    // A read-stage word that cannot move on keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_advance |=>
            s1_valid_reg && $stable(s1_left_reg) && $stable(s1_tidx_reg))
        else $error("stalled read stage lost its word");

    // An accepted symbol on the last position of a module moves the send pointer on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && do_symbol && !incoming && pos_last && !cfg_valid |=>
            send_ptr_reg == $past(send_ptr_reg) + RW'(1) && send_pos_reg == '0)
        else $error("send pointer did not advance at module end");

endmodule

`default_nettype wire

FILE: bench/otp_base64_symbol_cipher_checker.sv
// Checker for the one-time-pad symbol cipher: predicts every result word and compares it.
`timescale 1ns / 1ps

module otp_base64_symbol_cipher_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [otp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]                    s_axis_tuser,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [otp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [1:0]                    m_axis_tuser,
    input  wire logic                          m_axis_tlast,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [otp_pkg::REG_W-1:0]     cfg_data,
    output int unsigned                        fail_count,
    output int unsigned                        pending_words
);

    localparam int unsigned MOD_BYTES    = 18;
    localparam int unsigned MOD_COUNT    = 8192;
    localparam int unsigned REGION_BYTES = MOD_BYTES * MOD_COUNT;
    localparam int unsigned SYMS_PER_MOD = (MOD_BYTES / 3) * 4;
    localparam logic [511:0] ALPHABET =
        "_ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.";

    typedef struct packed {
        logic [otp_pkg::SYM_W-1:0] symbol;
        otp_pkg::status_t          status;
        logic                      done;
        logic [otp_pkg::REG_W-1:0] left;
    } cipher_result_t;

    logic [7:0]                pad_mem [0:2*REGION_BYTES-1];
    logic [otp_pkg::REG_W-1:0] send_start, send_end, recv_start, recv_end;
    logic [otp_pkg::REG_W-1:0] send_ptr, recv_ptr;
    int unsigned               send_pos, recv_pos;
    cipher_result_t            expected_q [$];
    int unsigned               err_total = 0;

    assign fail_count = err_total;

    function automatic logic [6:0] alpha_char(input logic [5:0] idx);
        logic [7:0] c;
        c = ALPHABET[511 - 8 * idx -: 8];
        return c[6:0];
    endfunction

    // Bytes outside the alphabet fall on the same index as the underscore.
    function automatic logic [5:0] alpha_index(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (ALPHABET[511 - 8 * i -: 8] == c) begin
                return 6'(i);
            end
        end
        return 6'd0;
    endfunction

    function automatic cipher_result_t encipher_word(input otp_pkg::mode_t mode,
                                                     input logic [7:0] text,
                                                     input logic [17:0] addr,
                                                     input logic [7:0] data);
        logic                      incoming;
        logic [otp_pkg::REG_W-1:0] ptr_now, end_now;
        int unsigned               pos_now, base, mod_base, bit_no, bi, sh;
        int unsigned               key, b0, b1, last_bit, k;
        cipher_result_t            r;
        incoming = mode[0];
        ptr_now  = incoming ? recv_ptr : send_ptr;
        pos_now  = incoming ? recv_pos : send_pos;
        end_now  = incoming ? recv_end : send_end;
        base     = incoming ? REGION_BYTES : 0;
        r = '0;
        if (mode == otp_pkg::MODE_LOAD_SEND || mode == otp_pkg::MODE_LOAD_RECV) begin
            if (addr < REGION_BYTES) begin
                pad_mem[base + addr] = data;
            end
            r.status = otp_pkg::STATUS_LOADED;
        end else if (ptr_now >= end_now || ptr_now >= MOD_COUNT) begin
            r.status = otp_pkg::STATUS_EXHAUSTED;
        end else begin
            mod_base = base + ptr_now * MOD_BYTES;
            bit_no   = pos_now * 6;
            bi       = bit_no >> 3;
            sh       = bit_no & 7;
            b0       = pad_mem[mod_base + bi];
            // Pad bits are taken most significant first; a key may straddle two bytes.
            if (sh <= 2) begin
                key = (b0 >> (2 - sh)) & 63;
            end else begin
                b1  = pad_mem[mod_base + bi + 1];
                key = ((b0 << (sh - 2)) | (b1 >> (10 - sh))) & 63;
            end
            r.symbol = alpha_char(alpha_index(text) ^ key[5:0]);
            last_bit = bit_no + 5;
            if ((last_bit & 7) == 7) begin
                pad_mem[mod_base + (last_bit >> 3)] = 8'd0;
            end else if ((last_bit >> 3) > bi) begin
                pad_mem[mod_base + bi] = 8'd0;
            end
            pos_now++;
            if (pos_now >= SYMS_PER_MOD) begin
                for (k = (MOD_BYTES / 3) * 3; k < MOD_BYTES; k++) begin
                    pad_mem[mod_base + k] = 8'd0;
                end
                pos_now = 0;
                ptr_now = ptr_now + 1'b1;
                r.done  = 1'b1;
            end
            r.status = otp_pkg::STATUS_SYMBOL;
        end
        if (incoming) begin
            recv_ptr = ptr_now;
            recv_pos = pos_now;
        end else begin
            send_ptr = ptr_now;
            send_pos = pos_now;
        end
        r.left = (end_now > ptr_now) ? end_now - ptr_now : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_total++;
        end
    endtask

    always @(posedge aclk) begin : watch
        cipher_result_t want;
        if (!aresetn) begin
            send_start = '0;
            send_end   = 14'd8192;
            recv_start = '0;
            recv_end   = 14'd8192;
            send_ptr   = '0;
            recv_ptr   = '0;
            send_pos   = 0;
            recv_pos   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (otp_pkg::cfg_index_t'(cfg_index))
                    otp_pkg::CFG_SEND_START: begin
                        send_start = cfg_data;
                        send_ptr   = cfg_data;
                        send_pos   = 0;
                    end
                    otp_pkg::CFG_SEND_END: begin
                        send_end = cfg_data;
                    end
                    otp_pkg::CFG_RECV_START: begin
                        recv_start = cfg_data;
                        recv_ptr   = cfg_data;
                        recv_pos   = 0;
                    end
                    default: begin
                        recv_end = cfg_data;
                    end
                endcase
            end
            // The result word of this edge always belongs to an older input word.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, tdata %0h tuser %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    err_total++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("symbol_out", want.symbol, m_axis_tdata[6:0]);
                    check_field("modules_left", want.left, m_axis_tdata[20:7]);
                    check_field("status", want.status, m_axis_tuser);
                    check_field("module_done", want.done, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(encipher_word(otp_pkg::mode_t'(s_axis_tuser),
                                                   s_axis_tdata[7:0],
                                                   s_axis_tdata[25:8],
                                                   s_axis_tdata[33:26]));
            end
        end
        pending_words <= expected_q.size();
    end

endmodule

FILE: bench/otp_base64_symbol_cipher_tb.sv
// Top of the cipher testbench: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module otp_base64_symbol_cipher_tb;

    localparam int unsigned PAD_MOD_BYTES = 18;
    localparam int unsigned PAD_MODS      = 8192;
    localparam int unsigned REGION_END    = PAD_MOD_BYTES * PAD_MODS;
    localparam int unsigned IDLE_LIMIT    = 2000;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic [otp_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]                    s_axis_tuser  = '0;
    logic                          m_axis_tready = 1'b0;
    logic                          cfg_valid     = 1'b0;
    logic [1:0]                    cfg_index     = '0;
    logic [otp_pkg::REG_W-1:0]     cfg_data      = '0;
    wire logic                          s_axis_tready;
    wire logic                          m_axis_tvalid;
    wire logic [otp_pkg::M_TDATA_W-1:0] m_axis_tdata;
    wire logic [1:0]                    m_axis_tuser;
    wire logic                          m_axis_tlast;
    wire logic                          cfg_ready;
    int unsigned                        fail_count;
    int unsigned                        pending_words;

    // Stimulus-side view of the pointers, so that no symbol reads an unloaded module.
    logic [otp_pkg::REG_W-1:0] trk_ptr [2];
    logic [otp_pkg::REG_W-1:0] trk_end [2];
    int unsigned               trk_pos [2];
    bit                        mod_loaded [2][PAD_MODS];
    bit                        no_gaps    = 1'b0;
    int unsigned               ready_hold = 0;
    int unsigned               idle_cycles = 0;
    int unsigned               n_words = 0, n_symbols = 0, n_loads = 0, n_settings = 0;

    otp_base64_symbol_cipher uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    otp_base64_symbol_cipher_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Receiver: bursts of readiness broken by stalls, mostly short and now and then long.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (no_gaps || $urandom_range(0, 99) < 60) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= no_gaps ? 0 : $urandom_range(0, 8);
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold    <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("otp_base64_symbol_cipher_tb: errors");
            $finish;
        end
    end

    function automatic logic [7:0] rand_text();
        if ($urandom_range(0, 1) == 1) begin
            return {1'b0, otp_pkg::sym_char(6'($urandom_range(0, 63)))};
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_word(input otp_pkg::mode_t mode, input logic [7:0] text,
                             input logic [17:0] addr, input logic [7:0] data);
        int unsigned g;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, data, addr, text};
        s_axis_tuser  <= mode;
        do @(posedge aclk); while (!s_axis_tready);
        n_words++;
    endtask

    task automatic load_byte(input int dir, input logic [17:0] addr, input logic [7:0] data);
        push_word(dir ? otp_pkg::MODE_LOAD_RECV : otp_pkg::MODE_LOAD_SEND, rand_text(),
                  addr, data);
        n_loads++;
    endtask

    // Fills a whole module, bytes in shuffled order.
    task automatic load_module(input int dir, input int unsigned m);
        int unsigned order [PAD_MOD_BYTES];
        int unsigned j, tmp;
        for (int i = 0; i < PAD_MOD_BYTES; i++) begin
            order[i] = i;
        end
        for (int i = PAD_MOD_BYTES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < PAD_MOD_BYTES; i++) begin
            load_byte(dir, 18'(m * PAD_MOD_BYTES + order[i]), 8'($urandom_range(0, 255)));
        end
        mod_loaded[dir][m] = 1'b1;
    endtask

    task automatic cipher_char(input int dir, input logic [7:0] text);
        bit spent;
        spent = (trk_ptr[dir] >= trk_end[dir]) || (trk_ptr[dir] >= PAD_MODS);
        if (!spent && !mod_loaded[dir][trk_ptr[dir]]) begin
            load_module(dir, trk_ptr[dir]);
        end
        push_word(dir ? otp_pkg::MODE_RECV : otp_pkg::MODE_SEND, text,
                  18'($urandom_range(0, 262143)), 8'($urandom_range(0, 255)));
        n_symbols++;
        if (!spent) begin
            trk_pos[dir]++;
            if (trk_pos[dir] == (PAD_MOD_BYTES / 3) * 4) begin
                trk_pos[dir] = 0;
                trk_ptr[dir] = trk_ptr[dir] + 1'b1;
            end
        end
    endtask

    // Stops the input side and waits until every result word has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input otp_pkg::cfg_index_t idx, input logic [13:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            otp_pkg::CFG_SEND_START: begin
                trk_ptr[0] = val;
                trk_pos[0] = 0;
            end
            otp_pkg::CFG_SEND_END: begin
                trk_end[0] = val;
            end
            otp_pkg::CFG_RECV_START: begin
                trk_ptr[1] = val;
                trk_pos[1] = 0;
            end
            default: begin
                trk_end[1] = val;
            end
        endcase
    endtask

    task automatic set_modules(input logic [13:0] ss, input logic [13:0] se,
                               input logic [13:0] rs, input logic [13:0] re);
        drain();
        write_reg(otp_pkg::CFG_SEND_START, ss);
        write_reg(otp_pkg::CFG_SEND_END, se);
        write_reg(otp_pkg::CFG_RECV_START, rs);
        write_reg(otp_pkg::CFG_RECV_END, re);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [13:0] pick_start();
        case ($urandom_range(0, 3))
            0: return 14'd0;
            1: return 14'(8192 - $urandom_range(0, 2));
            default: return 14'($urandom_range(0, 8192));
        endcase
    endfunction

    function automatic logic [13:0] pick_end(input logic [13:0] start);
        int unsigned e;
        case ($urandom_range(0, 2))
            0: begin
                e = start + $urandom_range(0, 2);
                return (e > 8192) ? 14'd8192 : 14'(e);
            end
            1: return 14'd8192;
            default: return 14'($urandom_range(0, 8192));
        endcase
    endfunction

    task automatic random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            cipher_char($urandom_range(0, 1), rand_text());
        end else if (r < 90) begin
            load_byte($urandom_range(0, 1), 18'($urandom_range(0, REGION_END - 1)),
                      8'($urandom_range(0, 255)));
        end else begin
            load_byte($urandom_range(0, 1), 18'($urandom_range(REGION_END, 262143)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        logic [13:0] ss, rs;
        trk_ptr[0] = '0;
        trk_ptr[1] = '0;
        trk_end[0] = 14'd8192;
        trk_end[1] = 14'd8192;
        trk_pos[0] = 0;
        trk_pos[1] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register values straight out of reset; loads at the region edges and past them.
        load_byte(0, 18'd0, 8'hFF);
        load_byte(0, 18'(REGION_END - 1), 8'h00);
        load_byte(0, 18'(REGION_END), 8'hA5);
        load_byte(1, 18'h3FFFF, 8'h5A);
        cipher_char(0, "_");
        cipher_char(0, ".");
        cipher_char(0, "A");
        cipher_char(0, "z");
        cipher_char(0, "0");
        cipher_char(0, "9");
        cipher_char(0, 8'h00);
        cipher_char(0, 8'hFF);
        cipher_char(1, "Z");
        cipher_char(1, "a");
        cipher_char(1, 8'h80);
        cipher_char(1, 8'h2F);

        // Last module of the store, then running off its end.
        set_modules(14'd8191, 14'd8192, 14'd8192, 14'd8192);
        for (int i = 0; i < 26; i++) begin
            cipher_char(0, rand_text());
        end
        cipher_char(1, "q");

        // Pointer past the store while its end register lies further out.
        no_gaps = 1'b1;
        set_modules(14'd8192, 14'h3FFF, 14'd0, 14'd0);
        cipher_char(0, "b");
        cipher_char(1, "c");
        load_byte(0, 18'd5, 8'h3C);

        for (int ph = 0; ph < 5; ph++) begin
            no_gaps = (ph == 1) || ($urandom_range(0, 3) == 0);
            if (ph == 0) begin
                set_modules(14'd0, 14'd8192, 14'd0, 14'd8192);
            end else begin
                ss = pick_start();
                rs = pick_start();
                set_modules(ss, pick_end(ss), rs, pick_end(rs));
            end
            for (int i = 0; i < 55; i++) begin
                random_item();
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("Sent %0d words: %0d symbols and %0d pad loads over %0d register settings.",
                 n_words, n_symbols, n_loads, n_settings);
        if (fail_count == 0 && pending_words == 0) begin
            $display("otp_base64_symbol_cipher_tb: clean");
        end else begin
            $display("otp_base64_symbol_cipher_tb: errors");
        end
        $finish;
    end

endmodule
